@@ hw/rtl/cdt_pkg.sv @@
package cdt_pkg;

   localparam logic [7:0] MaxMinutesReset = 8'd240;
   localparam logic [5:0] SecondsTop      = 6'd59;

   localparam logic [1:0] ACT_ENCODER = 2'd0;
   localparam logic [1:0] ACT_SWITCH  = 2'd1;
   localparam logic [1:0] ACT_BUTTON  = 2'd2;
   localparam logic [1:0] ACT_TICK    = 2'd3;

   localparam logic [1:0] MODE_CODE_SETTING  = 2'd0;
   localparam logic [1:0] MODE_CODE_RUNNING  = 2'd1;
   localparam logic [1:0] MODE_CODE_ALARMING = 2'd2;

   typedef enum logic [2:0] {
      MODE_SETTING  = 3'b001,
      MODE_RUNNING  = 3'b010,
      MODE_ALARMING = 3'b100
   } mode_type;

   typedef struct packed {
      logic [1:0]        action;
      logic signed [7:0] encoder_step;
      logic              pressed;
   } timer_req_type;

   typedef struct packed {
      logic [7:0] minutes_now;
      logic [5:0] seconds_now;
      logic [1:0] mode;
      logic       editing_seconds;
      logic       indicator_on;
      logic       alarm_active;
      logic       alarm_start;
      logic       display_changed;
   } timer_rsp_type;

endpackage

@@ hw/rtl/countdown_timer_set_run_alarm.sv @@
// Minutes:seconds countdown timer with setting, running and alarming modes.
// Request channel (req_valid/req_ready/req_data): one beat per event, either an
// encoder step, a switch or button edge, or a one-second tick.
// Response channel (rsp_valid/rsp_ready/rsp_data): exactly one beat per request,
// carrying the time, mode, field selection and alarm flags after that event.
// CSR port (csr_wr_en/csr_wr_data): writes the minutes limit used while setting;
// write only while no events are in flight.
// Path: a request beat is held in an input register; the update is a single
// short combinational step from there into the response register, which
// holds the response beat until it is taken.
// Throughput: one event per cycle while the response channel is not stalled.
// A stalled response holds in its register; a new request is still taken while
// the input register is free, and both sides stop when both registers are full.
// Reset: time 0:00, setting mode, minutes selected, limit 240, both registers
// empty.
module countdown_timer_set_run_alarm
   import cdt_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  timer_req_type req_data,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output timer_rsp_type rsp_data,
   input  logic          csr_wr_en,
   input  logic [7:0]    csr_wr_data
);

   timer_req_type req_ff;
   logic          req_valid_ff;
   timer_rsp_type rsp_ff, rsp_in;
   logic          rsp_valid_ff;
   logic [7:0]    max_minutes_ff;
   mode_type      mode_ff, mode_in;
   logic          field_ff, field_in;
   logic [7:0]    minutes_ff, minutes_in;
   logic [5:0]    seconds_ff, seconds_in;
   logic          advance;

   assign advance   = req_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !req_valid_ff || advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      logic              setting;
      logic              pulse;
      logic signed [9:0] step_ext;
      logic signed [9:0] min_sum;
      logic signed [9:0] sec_sum;
      setting    = (mode_ff != MODE_RUNNING) && (mode_ff != MODE_ALARMING);
      pulse      = 1'b0;
      mode_in    = mode_ff;
      field_in   = field_ff;
      minutes_in = minutes_ff;
      seconds_in = seconds_ff;
      step_ext   = signed'({{2{req_ff.encoder_step[7]}}, req_ff.encoder_step});
      min_sum    = signed'({2'b00, minutes_ff}) + step_ext;
      sec_sum    = signed'({4'b0000, seconds_ff}) + step_ext;
      unique case (req_ff.action)
         ACT_ENCODER: begin
            if (setting) begin
               if (!field_ff) begin
                  if (min_sum < 0) begin
                     minutes_in = '0;
                  end else if (min_sum > signed'({2'b00, max_minutes_ff})) begin
                     minutes_in = max_minutes_ff;
                  end else begin
                     minutes_in = min_sum[7:0];
                  end
               end else begin
                  if (sec_sum < 0) begin
                     seconds_in = '0;
                  end else if (sec_sum > signed'({4'b0000, SecondsTop})) begin
                     seconds_in = SecondsTop;
                  end else begin
                     seconds_in = sec_sum[5:0];
                  end
               end
            end
         end
         ACT_SWITCH: begin
            if (req_ff.pressed && setting) begin
               field_in = !field_ff;
            end
         end
         ACT_BUTTON: begin
            if (req_ff.pressed) begin
               if (!setting) begin
                  mode_in = MODE_SETTING;
               end else if ((minutes_ff != '0) || (seconds_ff != '0)) begin
                  mode_in = MODE_RUNNING;
               end
            end
         end
         ACT_TICK: begin
            if (mode_ff == MODE_RUNNING) begin
               if (seconds_ff != '0) begin
                  seconds_in = seconds_ff - 6'd1;
               end else if (minutes_ff != '0) begin
                  minutes_in = minutes_ff - 8'd1;
                  seconds_in = SecondsTop;
               end
               if ((minutes_in == '0) && (seconds_in == '0)) begin
                  mode_in = MODE_ALARMING;
                  pulse   = 1'b1;
               end
            end
         end
         default: ;
      endcase

      rsp_in.minutes_now     = minutes_in;
      rsp_in.seconds_now     = seconds_in;
      unique case (mode_in)
         MODE_RUNNING:  rsp_in.mode = MODE_CODE_RUNNING;
         MODE_ALARMING: rsp_in.mode = MODE_CODE_ALARMING;
         default:       rsp_in.mode = MODE_CODE_SETTING;
      endcase
      rsp_in.editing_seconds = field_in;
      rsp_in.indicator_on    = (mode_in != MODE_RUNNING) && (mode_in != MODE_ALARMING);
      rsp_in.alarm_active    = (mode_in == MODE_ALARMING);
      rsp_in.alarm_start     = pulse;
      rsp_in.display_changed = (minutes_in != minutes_ff) || (seconds_in != seconds_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff   <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         max_minutes_ff <= MaxMinutesReset;
         mode_ff        <= MODE_SETTING;
         field_ff       <= 1'b0;
         minutes_ff     <= '0;
         seconds_ff     <= '0;
      end else begin
         if (req_valid && req_ready) begin
            req_valid_ff <= 1'b1;
         end else if (advance) begin
            req_valid_ff <= 1'b0;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_wr_en) begin
            max_minutes_ff <= csr_wr_data;
         end
         if (advance) begin
            mode_ff    <= mode_in;
            field_ff   <= field_in;
            minutes_ff <= minutes_in;
            seconds_ff <= seconds_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         req_ff <= req_data;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule
